// ----- hdl/bmh_pkg.sv -----
// Shared constants and result codes for the binary min-heap.
package bmh_pkg;

	localparam int KEY_W        = 64;
	localparam int CAPACITY_DEF = 1024;
	localparam int CNT_OUT_W    = 11;
	localparam int STATUS_W     = 2;
	localparam int OUT_TDATA_W  = 144;
	localparam int OUT_TUSER_W  = 3;

	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ----- hdl/binary_min_heap.sv -----
// Top level of the binary min-heap priority queue.
//
//  channel  dir  tdata (low bit up)                              tuser (low bit up)
//  s_*      in   key[63:0]                                       command[0]
//  m_*      out  extracted[63:0] minimum[127:64] count[138:128]  status[1:0] has_minimum[2]
//
// An insert moves its key up from the new leaf and an extract moves the last entry down from
// the root, one level per read of the store, at most log2 of the capacity levels. A rejected
// command, or an extract that empties the heap, goes straight to the final output state.
// The store's read ports are registered, so each level waits for its read data.
// The root is mirrored in a register, so the removed key and the minimum need no read.
// Reset empties the heap at once; the store itself is never cleared.
// One command is in work at a time; a finished word waits in the output register.
module binary_min_heap #(
	parameter int CAPACITY = bmh_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bmh_pkg::KEY_W-1:0]      s_tdata,  // key
	input  logic [0:0]                     s_tuser,  // command
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bmh_pkg::OUT_TDATA_W-1:0] m_tdata, // extracted, minimum, entry_count, pad
	output logic [bmh_pkg::OUT_TUSER_W-1:0] m_tuser  // status, has_minimum
);
	import bmh_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;
	localparam int EW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
	localparam int PAD_W = OUT_TDATA_W - 2 * KEY_W - CNT_OUT_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UP    = 3'd1;
	localparam logic [2:0] S_LAST  = 3'd2;
	localparam logic [2:0] S_DOWN  = 3'd3;
	localparam logic [2:0] S_PLACE = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]          state_q;
	logic [CW-1:0]       cnt_q;
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       par_q;
	logic [AW-1:0]       lc_q;
	logic                rc_ok_q;
	logic [KEY_W-1:0]    key_q;
	logic [KEY_W-1:0]    root_q;
	logic [KEY_W-1:0]    removed_q;
	logic [STATUS_W-1:0] status_q;

	logic                ov_q;
	logic [STATUS_W-1:0] o_status_q;
	logic [KEY_W-1:0]    o_extracted_q;
	logic                o_hasmin_q;
	logic [KEY_W-1:0]    o_min_q;
	logic [CNT_OUT_W-1:0] o_cnt_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [KEY_W-1:0] wdata;
	logic [AW-1:0]    raddr_a;
	logic [AW-1:0]    raddr_b;
	logic [KEY_W-1:0] rd_a;
	logic [KEY_W-1:0] rd_b;

	logic             acc;
	logic             is_full;
	logic             pick_b;
	logic [KEY_W-1:0] pick_key;
	logic [AW-1:0]    pick_addr;
	logic             down_go;
	logic             up_go;
	logic [AW-1:0]    cp;
	logic [XW-1:0]    lc_w;
	logic [XW-1:0]    cnt_w;
	logic             has_lc;
	logic             has_rc;
	logic [AW-1:0]    up_p;
	logic [AW-1:0]    up_par;
	logic             out_free;
	logic [EW-1:0]    cnt_ext;

	bmh_store #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign is_full  = (cnt_q == CW'(CAPACITY));
	assign out_free = !ov_q || m_tready;
	assign cnt_ext  = EW'(cnt_q);

	always_comb begin
		// smaller child; the right one only when strictly smaller
		pick_b    = rc_ok_q && ($signed(rd_b) < $signed(rd_a));
		pick_key  = pick_b ? rd_b : rd_a;
		pick_addr = pick_b ? (lc_q + AW'(1)) : lc_q;
		down_go   = $signed(pick_key) < $signed(key_q);
		up_go     = $signed(key_q) < $signed(rd_a);

		cp     = (state_q == S_DOWN) ? pick_addr : '0;
		lc_w   = XW'({cp, 1'b1});
		cnt_w  = XW'(cnt_q);
		has_lc = lc_w < cnt_w;
		has_rc = (lc_w + XW'(1)) < cnt_w;

		up_p   = (state_q == S_UP) ? par_q : cnt_q[AW-1:0];
		up_par = (up_p - AW'(1)) >> 1;

		we      = 1'b0;
		waddr   = pos_q;
		wdata   = key_q;
		raddr_a = up_par;
		raddr_b = AW'(lc_w + XW'(1));
		unique case (state_q)
			S_IDLE: begin
				if (s_tuser[0] == CMD_EXTRACT) begin
					raddr_a = AW'(cnt_q - CW'(1));
				end
			end
			S_UP: begin
				if (up_go) begin
					we    = 1'b1;
					wdata = rd_a;
				end
			end
			S_LAST: begin
				raddr_a = AW'(lc_w);
			end
			S_DOWN: begin
				raddr_a = AW'(lc_w);
				if (down_go) begin
					we    = 1'b1;
					wdata = pick_key;
				end
			end
			S_PLACE: begin
				we = 1'b1;
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			pos_q         <= '0;
			par_q         <= '0;
			lc_q          <= '0;
			rc_ok_q       <= 1'b0;
			key_q         <= '0;
			root_q        <= '0;
			removed_q     <= '0;
			status_q      <= ST_OK;
			ov_q          <= 1'b0;
			o_status_q    <= ST_OK;
			o_extracted_q <= '0;
			o_hasmin_q    <= 1'b0;
			o_min_q       <= '0;
			o_cnt_q       <= '0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				ov_q <= 1'b1;
			end else if (ov_q && m_tready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						removed_q <= '0;
						status_q  <= ST_OK;
						if (s_tuser[0] == CMD_INSERT) begin
							if (is_full) begin
								status_q <= ST_FULL;
								state_q  <= S_FIN;
							end else begin
								cnt_q <= cnt_q + CW'(1);
								key_q <= s_tdata;
								pos_q <= cnt_q[AW-1:0];
								par_q <= up_par;
								state_q <= (cnt_q == '0) ? S_PLACE : S_UP;
							end
						end else begin
							if (cnt_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_FIN;
							end else begin
								removed_q <= root_q;
								cnt_q     <= cnt_q - CW'(1);
								pos_q     <= '0;
								state_q   <= (cnt_q == CW'(1)) ? S_FIN : S_LAST;
							end
						end
					end
				end
				S_UP: begin
					if (up_go) begin
						pos_q <= par_q;
						par_q <= up_par;
						if (par_q == '0) begin
							state_q <= S_PLACE;
						end
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_LAST: begin
					// last entry becomes the moving key, hole at the root
					key_q   <= rd_a;
					lc_q    <= AW'(lc_w);
					rc_ok_q <= has_rc;
					state_q <= has_lc ? S_DOWN : S_PLACE;
				end
				S_DOWN: begin
					if (down_go) begin
						if (pos_q == '0) begin
							root_q <= pick_key;
						end
						pos_q   <= pick_addr;
						lc_q    <= AW'(lc_w);
						rc_ok_q <= has_rc;
						if (!has_lc) begin
							state_q <= S_PLACE;
						end
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					if (pos_q == '0) begin
						root_q <= key_q;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						o_status_q    <= status_q;
						o_extracted_q <= removed_q;
						o_hasmin_q    <= (cnt_q != '0);
						o_min_q       <= (cnt_q != '0) ? root_q : '0;
						o_cnt_q       <= cnt_ext[CNT_OUT_W-1:0];
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {{PAD_W{1'b0}}, o_cnt_q, o_min_q, o_extracted_q};
	assign m_tuser  = {o_hasmin_q, o_status_q};

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("fill count beyond capacity");

	a_root_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		(we && waddr == '0) |=> (root_q == $past(wdata)))
		else $error("root register out of step with the store");

	a_child_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DOWN) |-> (XW'(lc_q) < XW'(cnt_q)))
		else $error("sift down reads beyond the fill count");

	a_reject_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tuser[0] == CMD_EXTRACT && cnt_q == '0)
		|=> (cnt_q == '0 && status_q == ST_EMPTY))
		else $error("extract from empty heap changed the count");
`endif

endmodule

// ----- hdl/bmh_store.sv -----
// Key store: one write port, two registered read ports.
module bmh_store #(
	parameter int DEPTH = bmh_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(bmh_pkg::CAPACITY_DEF)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [bmh_pkg::KEY_W-1:0] wdata,
	input  logic [AW-1:0]             raddr_a,
	input  logic [AW-1:0]             raddr_b,
	output logic [bmh_pkg::KEY_W-1:0] rdata_a,
	output logic [bmh_pkg::KEY_W-1:0] rdata_b
);
	import bmh_pkg::*;

	logic [KEY_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
